### src/sorted_priority_queue_macros.svh
// assertion macros shared by the sorted priority queue rtl
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SPQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq check failed");
// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq check failed");
`else
`define SPQ_ASSERT_IMP(label, ante, cons)
`define SPQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

### src/spq_pkg.sv
// shared types, codes and defaults for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;
  localparam int STATUS_BITS     = 2;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

  // per-cell control for one beat
  typedef struct packed {
    logic insert;  // insert that fits
    logic pop;     // pop on a non-empty queue
    logic held;    // this cell holds a live key
  } spq_ctl_t;

endpackage

### src/sorted_priority_queue.sv
// top level of the sorted min-priority queue: control, count and the cell row
// depends on spq_pkg, spq_cell and sorted_priority_queue_macros.svh
//
// usage
//   command channel: drive opcode and key with start high; the beat is taken
//   on any rising edge where start is high and busy is low. busy stays low,
//   so a command can be issued on every cycle.
//   result channel: done pulses for one cycle with status, popped_key and
//   fill_count. the receiver cannot stall; each result shows for one cycle.
//   latency: the result of a command appears in the cycle right after it is
//   taken. throughput: one command per cycle, set by the row of cells that
//   all compare against the new key and shift together.
//   insert: every cell compares its key with the new key in parallel; cells
//   at or past the sorted spot take their left neighbor's key, the first
//   of them takes the new key. equal keys place the new one first.
//   pop: every cell but the last takes its right neighbor's key; cell 0 is returned.
//   an insert into a full queue reports full, a pop on an empty queue
//   reports empty; the contents stay untouched in both cases.
//   reset: rst (synchronous) empties the queue and drops done; key storage
//   is not cleared, the count marks which cells are live.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   opcode,
  input  logic [KEY_BITS-1:0]    key,
  output logic                   done,
  output logic [STATUS_BITS-1:0] status,
  output logic [KEY_BITS-1:0]    popped_key,
  output logic [CNT_W-1:0]       fill_count
);

  `include "sorted_priority_queue_macros.svh"

  // live key count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic accept;
  logic is_full;
  logic is_empty;
  logic do_insert;
  logic do_pop;

  logic [STATUS_BITS-1:0] status_next;

  // cell row wiring
  logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
  logic                cell_lt  [QUEUE_DEPTH];

  // never stalls: busy is tied low
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);
  assign do_insert = accept && (opcode == OP_INSERT) && !is_full;
  assign do_pop    = accept && (opcode == OP_POP) && !is_empty;

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      count_next = count - CNT_W'(1);
    end
    if (opcode == OP_INSERT && is_full) begin
      status_next = ST_FULL;
    end else if (opcode == OP_POP && is_empty) begin
      status_next = ST_EMPTY;
    end
  end

  // the row of cells, neighbor keys passed left and right
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_ctl_t            ctl;
    logic [KEY_BITS-1:0] left_key;
    logic                left_lt;
    logic [KEY_BITS-1:0] right_key;

    assign ctl.insert = do_insert;
    assign ctl.pop    = do_pop;
    assign ctl.held   = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      // head acts as if a smaller key sat to its left
      assign left_key = key;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_lt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_mid
      assign right_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_key   (key),
      .left_key  (left_key),
      .left_lt   (left_lt),
      .right_key (right_key),
      .key_q     (cell_key[i]),
      .lt        (cell_lt[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      popped_key <= do_pop ? cell_key[0] : '0;
    end
  end

  // count already reflects the finished beat when done is shown
  assign fill_count = count;

  // assertions
  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT_NXT(a_insert_grows, do_insert, count == $past(count) + CNT_W'(1))
  `SPQ_ASSERT_NXT(a_empty_pop, accept && opcode == OP_POP && is_empty,
                  done && status == ST_EMPTY && fill_count == '0)
  `SPQ_ASSERT_IMP(a_head_sorted, count >= CNT_W'(2), cell_key[0] <= cell_key[1])

endmodule

### src/spq_cell.sv
// one cell of the sorted shift array: holds one key, compares it to the new key
// depends on spq_pkg
module spq_cell import spq_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  spq_ctl_t            ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_lt,
  input  logic [KEY_BITS-1:0] right_key,
  output logic [KEY_BITS-1:0] key_q,
  output logic                lt
);

  logic [KEY_BITS-1:0] key_next;

  // held key strictly below the new one stays put on insert
  assign lt = ctl.held && (key_q < new_key);

  always_comb begin
    key_next = key_q;
    if (ctl.insert && !lt) begin
      key_next = left_lt ? new_key : left_key;
    end else if (ctl.pop) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_next;
  end

endmodule

### sim/tb_top.sv
// self-checking testbench for sorted_priority_queue: directed, fill/drain, random and back-to-back command beats
// predicts each result with a sorted key list held here; depends on spq_pkg and the rtl top
module tb_top;
  import spq_pkg::*;

  localparam int DEPTH  = QUEUE_DEPTH_DEF;
  localparam int KW     = KEY_BITS_DEF;
  localparam int FILL_W = $clog2(DEPTH + 1);

  // one result beat as the block reports it
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [KW-1:0]          popped_key;
    logic [FILL_W-1:0]      fill_count;
  } queue_result_t;

  logic                   clk    = 1'b0;
  logic                   rst    = 1'b1;
  logic                   start  = 1'b0;
  logic                   opcode = OP_INSERT;
  logic [KW-1:0]          key    = '0;
  logic                   busy;
  logic                   done;
  logic [STATUS_BITS-1:0] status;
  logic [KW-1:0]          popped_key;
  logic [FILL_W-1:0]      fill_count;

  // keys the queue should hold, smallest first
  logic [KW-1:0] model_keys[$];
  // results owed by the block, oldest first
  queue_result_t pending_results[$];
  int unsigned error_count = 0;

  always #5 clk = ~clk;

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .KEY_BITS   (KW)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .key       (key),
    .done      (done),
    .status    (status),
    .popped_key(popped_key),
    .fill_count(fill_count)
  );

  // apply one command to the key list and return the result it should give
  function automatic queue_result_t apply_queue_op(input logic op, input logic [KW-1:0] k);
    queue_result_t r;
    int pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (model_keys.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // a new key equal to held ones goes in front of them
        pos = 0;
        while (pos < model_keys.size() && model_keys[pos] < k) pos++;
        model_keys.insert(pos, k);
        r.status = ST_DONE;
      end
    end else begin
      if (model_keys.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_key = model_keys.pop_front();
        r.status     = ST_DONE;
      end
    end
    r.fill_count = FILL_W'(model_keys.size());
    return r;
  endfunction

  // present one command beat and wait until it is taken; start stays high on return
  task automatic send_beat(input logic op, input logic [KW-1:0] k);
    start  <= 1'b1;
    opcode <= op;
    key    <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_queue_op(op, k));
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending until every owed result has shown up, or the limit runs out
  task automatic wait_for_results(input int unsigned limit);
    int unsigned n = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // keys mixed to hit extremes, duplicates and the full 32-bit range
  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return KW'($urandom_range(0, 15));
      4:       return ~(KW'($urandom_range(0, 15)));
      default: return $urandom();
    endcase
  endfunction

  // result checker: every done beat must match the oldest owed result
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d popped %h fill %0d",
                 $time, status, popped_key, fill_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status: expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (popped_key !== want.popped_key) begin
          $display("%0t: popped_key: expected %h actual %h", $time, want.popped_key, popped_key);
          error_count++;
        end
        if (fill_count !== want.fill_count) begin
          $display("%0t: fill_count: expected %0d actual %0d", $time, want.fill_count,
                   fill_count);
          error_count++;
        end
      end
    end
  end

  // extremes, equal keys, empty pop and ignored pop key
  task automatic test_directed();
    send_beat(OP_POP, '1);              // pop on an empty queue
    send_beat(OP_INSERT, 32'd5);
    send_beat(OP_INSERT, 32'd5);        // equal to the smallest
    send_beat(OP_INSERT, '0);
    send_beat(OP_INSERT, '1);
    send_beat(OP_INSERT, 32'h8000_0000);
    send_beat(OP_INSERT, 32'h7FFF_FFFF);
    hold_off(3);
    send_beat(OP_INSERT, 32'd1);
    send_beat(OP_INSERT, '0);           // duplicate of the smallest
    send_beat(OP_INSERT, 32'hAAAA_AAAA);
    send_beat(OP_INSERT, 32'h5555_5555);
    send_beat(OP_INSERT, '1);           // duplicate of the largest
    repeat (12) send_beat(OP_POP, $urandom());
    send_beat(OP_POP, '0);              // empty again
  endtask

  // fill to capacity, push against the full queue, then drain past empty
  task automatic test_full_queue();
    while (model_keys.size() < DEPTH) begin
      if ($urandom_range(0, 7) == 0) hold_off($urandom_range(1, 17));
      send_beat(OP_INSERT, pick_key());
    end
    repeat (3) send_beat(OP_INSERT, pick_key());
    send_beat(OP_POP, $urandom());
    send_beat(OP_INSERT, '0);           // refill the freed slot
    send_beat(OP_INSERT, '1);           // rejected again
    while (model_keys.size() > 0) begin
      if ($urandom_range(0, 7) == 0) hold_off($urandom_range(1, 17));
      send_beat(OP_POP, $urandom());
    end
    repeat (2) send_beat(OP_POP, $urandom());
  endtask

  // random mix in segments biased toward growing or shrinking, with idle bursts
  task automatic test_random(input int unsigned items);
    int unsigned insert_pct = 50;
    int unsigned seg_left   = 0;
    bit          idle_on    = 1'b0;
    for (int unsigned i = 0; i < items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 3))
          0:       insert_pct = 20;
          1:       insert_pct = 50;
          2:       insert_pct = 80;
          default: insert_pct = 95;
        endcase
        idle_on = ($urandom_range(0, 2) != 0);
      end
      seg_left--;
      // sender waits for the queue to answer everything once mid-run
      if (i == items / 2) wait_for_results(100);
      if (idle_on && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 17));
      send_beat(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_POP, pick_key());
    end
  endtask

  // closing stretch with a command every cycle
  task automatic test_back_to_back(input int unsigned items);
    repeat (items)
      send_beat(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_POP, pick_key());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_random(700);
    test_back_to_back(100);
    wait_for_results(200);
    // results are registered, so the extra hold-off catches any stray beat
    hold_off(5);
    if (pending_results.size() != 0) begin
      $display("%0t: missing results: expected %0d more, actual 0", $time,
               pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
